// ===== rtl/core/cpbf_pkg.sv =====
package cpbf_pkg;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_MOD,
        ST_FOLD,
        ST_SQR,
        ST_SUM,
        ST_CHECK,
        ST_SQRT,
        ST_EMIT,
        ST_NEXT,
        ST_FLUSH,
        ST_DROP
    } state_t;

    // Configuration register indexes
    localparam logic [2:0] REG_CUTOFF = 3'd0;
    localparam logic [2:0] REG_STIFF  = 3'd1;
    localparam logic [2:0] REG_BOX_X  = 3'd2;
    localparam logic [2:0] REG_BOX_Y  = 3'd3;
    localparam logic [2:0] REG_BOX_Z  = 3'd4;

    localparam int NUM_AXES   = 3;
    localparam int MOD_STEPS  = 35;   // bits of |2d + L|
    localparam int SQRT_STEPS = 32;   // root bits of a 64-bit value
    localparam int STEP_W     = 6;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic wr;
        logic diff_load;
        logic mod_step;
        logic fold;
        logic square;
        logic sum;
        logic sqrt_load;
        logic sqrt_step;
        logic pend_load;
        logic out_pend;
        logic out_drop;
        logic out_last;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic in_range;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/cpbf_ram.sv =====
module cpbf_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/cpbf_ctrl.sv =====
module cpbf_ctrl #(
    parameter int MAX_PARTICLES = 64,
    parameter int AW            = $clog2(MAX_PARTICLES),
    parameter int CW            = $clog2(MAX_PARTICLES + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_start,
    input  cpbf_pkg::dp_stat_t stat,
    output cpbf_pkg::dp_cmd_t  cmd,
    output logic [AW-1:0]      pair_idx,
    output logic [AW-1:0]      new_idx
);

    cpbf_pkg::state_t              state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 n_reg, n_next;
    logic [CW-1:0]                 i_reg, i_next;
    logic [cpbf_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [CW-1:0]                 eff_count;
    logic                          drop;

    assign eff_count = in_start ? '0 : count_reg;
    assign drop      = (eff_count == CW'(MAX_PARTICLES));
    assign new_idx   = (state_reg == cpbf_pkg::ST_IDLE) ? eff_count[AW-1:0] : n_reg[AW-1:0];
    assign pair_idx  = i_reg[AW-1:0];

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cpbf_pkg::ST_IDLE;
            count_reg      <= '0;
            n_reg          <= '0;
            i_reg          <= '0;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            n_reg          <= n_next;
            i_reg          <= i_next;
            step_reg       <= step_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        step_next       = step_reg;
        pend_valid_next = pend_valid_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        unique case (state_reg)
            cpbf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (drop)
                    begin
                        state_next = cpbf_pkg::ST_DROP;
                    end
                    else
                    begin
                        cmd.wr     = 1'b1;
                        count_next = eff_count + CW'(1);
                        n_next     = eff_count;
                        i_next     = '0;
                        state_next = (eff_count == '0) ? cpbf_pkg::ST_IDLE : cpbf_pkg::ST_READ;
                    end
                end
            end
            cpbf_pkg::ST_READ:
            begin
                state_next = cpbf_pkg::ST_DIFF;
            end
            cpbf_pkg::ST_DIFF:
            begin
                cmd.diff_load = 1'b1;
                step_next     = '0;
                state_next    = cpbf_pkg::ST_MOD;
            end
            cpbf_pkg::ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (step_reg == cpbf_pkg::STEP_W'(cpbf_pkg::MOD_STEPS - 1))
                begin
                    state_next = cpbf_pkg::ST_FOLD;
                end
                else
                begin
                    step_next = step_reg + cpbf_pkg::STEP_W'(1);
                end
            end
            cpbf_pkg::ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = cpbf_pkg::ST_SQR;
            end
            cpbf_pkg::ST_SQR:
            begin
                cmd.square = 1'b1;
                state_next = cpbf_pkg::ST_SUM;
            end
            cpbf_pkg::ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = cpbf_pkg::ST_CHECK;
            end
            cpbf_pkg::ST_CHECK:
            begin
                if (stat.in_range)
                begin
                    cmd.sqrt_load = 1'b1;
                    step_next     = '0;
                    state_next    = cpbf_pkg::ST_SQRT;
                end
                else
                begin
                    state_next = cpbf_pkg::ST_NEXT;
                end
            end
            cpbf_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == cpbf_pkg::STEP_W'(cpbf_pkg::SQRT_STEPS - 1))
                begin
                    state_next = cpbf_pkg::ST_EMIT;
                end
                else
                begin
                    step_next = step_reg + cpbf_pkg::STEP_W'(1);
                end
            end
            cpbf_pkg::ST_EMIT:
            begin
                // Hold the newest bond until we know whether it is the last
                if (!pend_valid_reg)
                begin
                    cmd.pend_load   = 1'b1;
                    pend_valid_next = 1'b1;
                    state_next      = cpbf_pkg::ST_NEXT;
                end
                else if (stat.out_free)
                begin
                    cmd.out_pend  = 1'b1;
                    cmd.pend_load = 1'b1;
                    state_next    = cpbf_pkg::ST_NEXT;
                end
            end
            cpbf_pkg::ST_NEXT:
            begin
                if (i_reg == n_reg - CW'(1))
                begin
                    state_next = cpbf_pkg::ST_FLUSH;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = cpbf_pkg::ST_READ;
                end
            end
            cpbf_pkg::ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = cpbf_pkg::ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.out_pend    = 1'b1;
                    cmd.out_last    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = cpbf_pkg::ST_IDLE;
                end
            end
            cpbf_pkg::ST_DROP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_drop = 1'b1;
                    state_next   = cpbf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cpbf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/cpbf_dp.sv =====
module cpbf_dp #(
    parameter int MAX_PARTICLES = 64,
    parameter int AW            = $clog2(MAX_PARTICLES)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cpbf_pkg::dp_cmd_t  cmd,
    output cpbf_pkg::dp_stat_t stat,
    input  logic [AW-1:0]      pair_idx,
    input  logic [AW-1:0]      new_idx,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata,
    input  logic [95:0]        in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [79:0]        out_data,
    output logic               out_status,
    output logic               out_last
);

    localparam int NA = cpbf_pkg::NUM_AXES;

    // Configuration
    logic [30:0]        cutoff_reg;
    logic [31:0]        stiff_reg;
    logic [30:0]        box_reg [NA];
    logic [61:0]        cut2_reg;

    // Per-pair work registers
    logic [31:0]        new_pos_reg [NA];
    logic [5:0]         later_reg;
    logic signed [32:0] diff_reg [NA];
    logic               neg_reg [NA];
    logic [34:0]        mag_reg [NA];
    logic [31:0]        rem_reg [NA];
    logic [31:0]        absd_reg [NA];
    logic [63:0]        sq_reg [NA];
    logic [63:0]        r2_reg;
    logic [63:0]        sqrt_src_reg;
    logic [33:0]        sqrt_rem_reg;
    logic [31:0]        sqrt_root_reg;
    logic [5:0]         pend_earlier_reg;
    logic [30:0]        pend_rest_reg;
    logic               out_valid_reg;
    logic [79:0]        out_data_reg;
    logic               out_status_reg;
    logic               out_last_reg;
    logic [95:0]        ram_rdata;

    // Combinational helpers
    logic signed [32:0] diff_c [NA];
    logic [34:0]        num_c [NA];
    logic [32:0]        den_c [NA];
    logic [32:0]        trial_c [NA];
    logic [31:0]        r_c [NA];
    logic signed [32:0] wrap_c [NA];
    logic signed [32:0] dsel_c [NA];
    logic [32:0]        abs_c [NA];
    logic [65:0]        sum_c;
    logic [35:0]        srem_c;
    logic [35:0]        strial_c;

    cpbf_ram #(
        .WIDTH (96),
        .DEPTH (MAX_PARTICLES)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr),
        .waddr (new_idx),
        .wdata (in_data),
        .raddr (pair_idx),
        .rdata (ram_rdata)
    );

    // Per-axis difference, remainder step and minimum-image fold
    always_comb
    begin
        for (int a = 0; a < NA; a++)
        begin
            diff_c[a]  = 33'(signed'(new_pos_reg[a])) - 33'(signed'(ram_rdata[32*a +: 32]));
            num_c[a]   = {diff_c[a][32], diff_c[a], 1'b0} + 35'(box_reg[a]);
            den_c[a]   = {1'b0, box_reg[a], 1'b0};
            trial_c[a] = {rem_reg[a], mag_reg[a][34]};
            r_c[a]     = (neg_reg[a] && (rem_reg[a] != '0)) ?
                         (den_c[a][31:0] - rem_reg[a]) : rem_reg[a];
            wrap_c[a]  = (signed'({1'b0, r_c[a]}) - signed'(33'(box_reg[a]))) >>> 1;
            dsel_c[a]  = (box_reg[a] == '0) ? diff_reg[a] : wrap_c[a];
            abs_c[a]   = dsel_c[a][32] ? 33'(-dsel_c[a]) : 33'(dsel_c[a]);
        end
        sum_c    = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
        srem_c   = {sqrt_rem_reg, sqrt_src_reg[63:62]};
        strial_c = {2'b00, sqrt_root_reg, 2'b01};
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= '0;
            stiff_reg  <= '0;
            for (int a = 0; a < NA; a++)
            begin
                box_reg[a] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                cpbf_pkg::REG_CUTOFF: cutoff_reg <= cfg_wdata[30:0];
                cpbf_pkg::REG_STIFF:  stiff_reg  <= cfg_wdata;
                cpbf_pkg::REG_BOX_X:  box_reg[0] <= cfg_wdata[30:0];
                cpbf_pkg::REG_BOX_Y:  box_reg[1] <= cfg_wdata[30:0];
                cpbf_pkg::REG_BOX_Z:  box_reg[2] <= cfg_wdata[30:0];
                default:              ;
            endcase
        end
    end

    // Work registers
    always_ff @(posedge clk)
    begin
        cut2_reg <= 62'(cutoff_reg) * 62'(cutoff_reg);
        if (cmd.accept)
        begin
            for (int a = 0; a < NA; a++)
            begin
                new_pos_reg[a] <= in_data[32*a +: 32];
            end
            later_reg <= 6'(new_idx);
        end
        for (int a = 0; a < NA; a++)
        begin
            if (cmd.diff_load)
            begin
                diff_reg[a] <= diff_c[a];
                neg_reg[a]  <= num_c[a][34];
                mag_reg[a]  <= num_c[a][34] ? 35'(-num_c[a]) : num_c[a];
                rem_reg[a]  <= '0;
            end
            if (cmd.mod_step)
            begin
                rem_reg[a] <= (trial_c[a] >= den_c[a]) ?
                              32'(trial_c[a] - den_c[a]) : trial_c[a][31:0];
                mag_reg[a] <= {mag_reg[a][33:0], 1'b0};
            end
            if (cmd.fold)
            begin
                absd_reg[a] <= abs_c[a][31:0];
            end
            if (cmd.square)
            begin
                sq_reg[a] <= absd_reg[a] * absd_reg[a];
            end
        end
        // Saturate the sum of squares
        if (cmd.sum)
        begin
            r2_reg <= (sum_c[65:64] != 2'b00) ? '1 : sum_c[63:0];
        end
        // Integer square root, one root bit a cycle
        if (cmd.sqrt_load)
        begin
            sqrt_src_reg  <= r2_reg;
            sqrt_rem_reg  <= '0;
            sqrt_root_reg <= '0;
        end
        if (cmd.sqrt_step)
        begin
            sqrt_src_reg <= {sqrt_src_reg[61:0], 2'b00};
            if (srem_c >= strial_c)
            begin
                sqrt_rem_reg  <= 34'(srem_c - strial_c);
                sqrt_root_reg <= {sqrt_root_reg[30:0], 1'b1};
            end
            else
            begin
                sqrt_rem_reg  <= srem_c[33:0];
                sqrt_root_reg <= {sqrt_root_reg[30:0], 1'b0};
            end
        end
        if (cmd.pend_load)
        begin
            pend_earlier_reg <= 6'(pair_idx);
            pend_rest_reg    <= sqrt_root_reg[30:0];
        end
        if (cmd.out_pend)
        begin
            out_data_reg   <= {5'b0, stiff_reg, pend_rest_reg, later_reg, pend_earlier_reg};
            out_status_reg <= 1'b0;
            out_last_reg   <= cmd.out_last;
        end
        else if (cmd.out_drop)
        begin
            out_data_reg   <= '0;
            out_status_reg <= 1'b1;
            out_last_reg   <= 1'b1;
        end
    end

    // Output request flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_pend || cmd.out_drop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.in_range = (r2_reg <= 64'(cut2_reg));
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign out_status    = out_status_reg;
    assign out_last      = out_last_reg;

endmodule

// ===== rtl/core/cutoff_pair_bond_finder_core.sv =====
// Accepts one particle request at a time; the store holds up to MAX_PARTICLES entries.
// Each stored particle passes through a 35-step remainder unit per axis, plus the
// bit-serial square root when it bonds. The last bond of an item is held and
// flushed at the end, and a stall on the result side holds the item.
// Reset (rst_n low, asynchronous) empties the store and clears the control state, configuration and output flag.
module cutoff_pair_bond_finder_core #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // pos_x, pos_y, pos_z
    input  logic        s_axis_tuser,   // starts_new_set
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // earlier_index, later_index, rest_length,
                                        // bond_stiffness, zero fill
    output logic        m_axis_tuser,   // status
    output logic        m_axis_tlast,   // last_of_run
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    localparam int AW = $clog2(MAX_PARTICLES);

    cpbf_pkg::dp_cmd_t  cmd;
    cpbf_pkg::dp_stat_t stat;
    logic [AW-1:0]      pair_idx;
    logic [AW-1:0]      new_idx;

    cpbf_ctrl #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_start (s_axis_tuser),
        .stat     (stat),
        .cmd      (cmd),
        .pair_idx (pair_idx),
        .new_idx  (new_idx)
    );

    cpbf_dp #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .pair_idx   (pair_idx),
        .new_idx    (new_idx),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_data    (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_status (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule

// ===== rtl/core/cpbf_checker.sv =====
module cpbf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Dropped particle gives a single all-zero, final result
    a_drop_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("malformed drop result");

    // A bond always pairs an earlier index with a later one
    a_bond_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[5:0] < m_axis_tdata[11:6]))
        else $error("bond indices out of order");

    // Reset leaves no result pending
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

endmodule

bind cutoff_pair_bond_finder_core cpbf_checker u_cpbf_checker (.*);
